// File: hw/rtl/sat_pkg.sv
// Shared types and constants for the sorted array table.
`timescale 1ns / 1ps
package sat_pkg;

  localparam int KEY_W     = 32;
  localparam int KIND_W    = 2;
  localparam int POS_W     = 4;
  localparam int CNT_W     = 5;
  localparam int STAT_W    = 2;
  localparam int DEPTH_DEF = 16;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_POS  = 2'd2
  } stat_code_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // latch a new operation
    logic       set_code;
    stat_code_t code;
    logic       ptr_count; // ptr <= count
    logic       ptr_pos;   // ptr <= position
    logic       ptr_dec;
    logic       ptr_inc;
    logic       rd_en;
    logic       wr_en;
    logic       wr_key;    // write key, else the word just read
    logic       capture;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_load;
  } sat_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_ins;
    logic is_look;
    logic is_rem;
    logic full;
    logic pos_bad;
    logic rm_last;
    logic rm_next_last;
    logic ptr_zero;
    logic key_le;      // word read is not less than the key
    logic out_free;
  } sat_stat_t;

endpackage

// File: hw/rtl/sat_op_if.sv
// Operation channel: valid/ready with kind, key and position.
`timescale 1ns / 1ps
interface sat_op_if
  import sat_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key_value;
  logic [POS_W-1:0]  position;

  modport source (output valid, kind, key_value, position, input ready);
  modport sink (input valid, kind, key_value, position, output ready);
endinterface

// File: hw/rtl/sat_res_if.sv
// Result channel: valid/ready with read value, entry count and status.
`timescale 1ns / 1ps
interface sat_res_if
  import sat_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  read_value;
  logic [CNT_W-1:0]  entry_count;
  logic [STAT_W-1:0] status;

  modport source (output valid, read_value, entry_count, status, input ready);
  modport sink (input valid, read_value, entry_count, status, output ready);
endinterface

// File: hw/rtl/sorted_array_table.sv
// Sorted array table: ordered store of unsigned keys with insert, lookup, remove.
// Insert shifts the entries not less than the key up one slot, from the top down; remove
// shifts the entries above the removed one down; lookup reads the entry at the position.
// Refused operations and the unused kind go straight to the result. One operation at a time:
// the next transfer in is accepted only after the result is loaded into the output register.
// Synchronous reset empties the store (count zero) and sets capacity to 16; no sweep.
`timescale 1ns / 1ps
module sorted_array_table
  import sat_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  sat_op_if.sink           op,
  sat_res_if.source        result
);

  sat_cmd_t  cmd;
  sat_stat_t stat;

  sat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op.valid),
    .op_ready (op.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sat_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .op_kind    (op.kind),
    .op_key     (op.key_value),
    .op_pos     (op.position),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_value  (result.read_value),
    .res_count  (result.entry_count),
    .res_status (result.status),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// File: hw/rtl/sat_ctrl.sv
// Controller state machine sequencing insert, lookup and remove walks.
`timescale 1ns / 1ps
module sat_ctrl
  import sat_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_ready,
  input  sat_stat_t stat,
  output sat_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign op_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (op_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        priority if (stat.is_ins) begin
          if (stat.full) begin
            cmd.set_code = 1'b1;
            cmd.code     = ST_FULL;
            state_next   = S_DONE;
          end else begin
            cmd.ptr_count = 1'b1;
            state_next    = S_READ;
          end
        end else if (stat.is_look || stat.is_rem) begin
          if (stat.pos_bad) begin
            cmd.set_code = 1'b1;
            cmd.code     = ST_POS;
            state_next   = S_DONE;
          end else if (stat.is_rem && stat.rm_last) begin
            cmd.cnt_dec = 1'b1;
            state_next  = S_DONE;
          end else begin
            cmd.ptr_pos = 1'b1;
            state_next  = S_READ;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        if (stat.is_ins && stat.ptr_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (stat.is_ins) begin
          cmd.wr_en = 1'b1;
          if (stat.key_le) begin
            cmd.ptr_dec = 1'b1;
            state_next  = S_READ;
          end else begin
            cmd.wr_key  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_next  = S_DONE;
          end
        end else if (stat.is_rem) begin
          cmd.wr_en   = 1'b1;
          cmd.ptr_inc = 1'b1;
          if (stat.rm_next_last) begin
            cmd.cnt_dec = 1'b1;
            state_next  = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end else begin
          cmd.capture = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/sat_dpath.sv
// Datapath: key store, count, capacity, walk pointer and result register.
`timescale 1ns / 1ps
module sat_dpath
  import sat_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic [KIND_W-1:0] op_kind,
  input  logic [KEY_W-1:0]  op_key,
  input  logic [POS_W-1:0]  op_pos,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [KEY_W-1:0]  res_value,
  output logic [CNT_W-1:0]  res_count,
  output logic [STAT_W-1:0] res_status,
  input  sat_cmd_t          cmd,
  output sat_stat_t         stat
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = AW + 6;

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] mem_q;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  capacity;
  kind_t             kind;
  logic [KEY_W-1:0]  key;
  logic [POS_W-1:0]  pos;
  logic [AW-1:0]     ptr;
  logic [KEY_W-1:0]  rd_val;
  stat_code_t        code;

  logic [AW-1:0]     raddr;
  logic [KEY_W-1:0]  wdata;
  logic [CMPW-1:0]   count_w;
  logic [CMPW-1:0]   limit_w;

  assign count_w = CMPW'(count);
  assign limit_w = (CMPW'(capacity) < CMPW'(DEPTH)) ? CMPW'(capacity) : CMPW'(DEPTH);

  always_comb begin
    unique case (kind)
      KIND_INSERT: raddr = ptr - AW'(1);
      KIND_REMOVE: raddr = ptr + AW'(1);
      default:     raddr = AW'(pos);
    endcase
  end

  assign wdata = cmd.wr_key ? key : mem_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[ptr] <= wdata;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind   <= kind_t'(op_kind);
      key    <= op_key;
      pos    <= op_pos;
      code   <= ST_OK;
      rd_val <= '0;
    end else begin
      if (cmd.set_code) begin
        code <= cmd.code;
      end
      if (cmd.capture) begin
        rd_val <= mem_q;
      end
    end
    if (cmd.ptr_count) begin
      ptr <= AW'(count);
    end else if (cmd.ptr_pos) begin
      ptr <= AW'(pos);
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - AW'(1);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_value  <= rd_val;
      res_count  <= count;
      res_status <= code;
    end
  end

  always_comb begin
    stat.is_ins       = (kind == KIND_INSERT);
    stat.is_look      = (kind == KIND_LOOKUP);
    stat.is_rem       = (kind == KIND_REMOVE);
    stat.full         = (count_w >= limit_w);
    stat.pos_bad      = (CMPW'(pos) >= count_w);
    stat.rm_last      = (CMPW'(pos) + CMPW'(1) >= count_w);
    stat.rm_next_last = (CMPW'(ptr) + CMPW'(2) >= count_w);
    stat.ptr_zero     = (ptr == '0);
    stat.key_le       = (mem_q >= key);
    stat.out_free     = !res_valid || res_ready;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count_w <= CMPW'(DEPTH))
    else $error("entry count exceeds depth");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !stat.full)
    else $error("insert committed while full");

  a_inc_step: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |=> count == $past(count) + CNT_W'(1))
    else $error("count did not advance on insert");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result overwritten before transfer");
`endif

endmodule
